/* rtl/deficit_round_robin_scheduler_assert.svh */
// Assertion macros shared by the scheduler checker.
// Depends on nothing; each user supplies clk and rst in scope.
`ifndef DEFICIT_ROUND_ROBIN_SCHEDULER_ASSERT_SVH
`define DEFICIT_ROUND_ROBIN_SCHEDULER_ASSERT_SVH

// cond must hold at every edge outside reset
`define DRR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// pre at one edge implies post at the next, outside reset
`define DRR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// checked through reset as well
`define DRR_ASSERT_RESET(label, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/drr_pkg.sv */
// Types and constants of the deficit round robin scheduler.
// Used by the scheduler top, drr_core and drr_checker; depends on nothing.
`timescale 1ns / 1ps

package drr_pkg;

  localparam int DEF_W       = 25;
  localparam int QUANT_W     = 24;
  localparam int FRAC_BITS   = 8;
  localparam int NUM_WEIGHTS = 4;
  localparam logic [DEF_W-1:0] DEFICIT_MAX = {DEF_W{1'b1}};

  localparam logic [15:0] BASE_RESET   = 16'd1500;
  localparam logic [15:0] WEIGHT_RESET = 16'd256;

  localparam logic [2:0] REG_BASE = 3'd0;
  localparam logic [2:0] REG_W0   = 3'd1;
  localparam logic [2:0] REG_W1   = 3'd2;
  localparam logic [2:0] REG_W2   = 3'd3;
  localparam logic [2:0] REG_W3   = 3'd4;

  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic        class_valid;
    logic [1:0]  class_index;
    logic [15:0] packet_length;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        served;
    logic [1:0]  served_class;
    logic [15:0] served_length;
  } result_t;

  typedef struct packed {
    logic [15:0]                  base_quantum;
    logic [NUM_WEIGHTS-1:0][15:0] weight;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VISIT,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

/* rtl/deficit_round_robin_scheduler.sv */
// Weighted deficit round robin scheduler: APB config registers and core.
// Depends on drr_pkg, drr_core, drr_ram.
// Enqueue: idle to done, where the result is registered; only idle takes requests.
// Dequeue visits classes in ring order (quantum product registered, then length
// RAM read and compare) until a packet is served or the ring is empty.
// Synchronous reset clears all queues, deficits and the ring; no RAM sweep.
`timescale 1ns / 1ps

module deficit_round_robin_scheduler #(
  parameter int NUM_CLASSES = 4,
  parameter int FIFO_DEPTH  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              item_valid,
  output logic              item_ready,
  input  drr_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output drr_pkg::result_t  result
);

  drr_pkg::cfg_t cfg;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_quantum <= drr_pkg::BASE_RESET;
      for (int i = 0; i < drr_pkg::NUM_WEIGHTS; i++) begin
        cfg.weight[i] <= drr_pkg::WEIGHT_RESET;
      end
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        drr_pkg::REG_BASE: cfg.base_quantum <= pwdata[15:0];
        drr_pkg::REG_W0:   cfg.weight[0]    <= pwdata[15:0];
        drr_pkg::REG_W1:   cfg.weight[1]    <= pwdata[15:0];
        drr_pkg::REG_W2:   cfg.weight[2]    <= pwdata[15:0];
        drr_pkg::REG_W3:   cfg.weight[3]    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      drr_pkg::REG_BASE: prdata = {16'b0, cfg.base_quantum};
      drr_pkg::REG_W0:   prdata = {16'b0, cfg.weight[0]};
      drr_pkg::REG_W1:   prdata = {16'b0, cfg.weight[1]};
      drr_pkg::REG_W2:   prdata = {16'b0, cfg.weight[2]};
      drr_pkg::REG_W3:   prdata = {16'b0, cfg.weight[3]};
      default:           prdata = '0;
    endcase
  end

  drr_core #(.NUM_CLASSES(NUM_CLASSES), .FIFO_DEPTH(FIFO_DEPTH)) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* rtl/drr_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module drr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/drr_core.sv */
// Scheduler sequencer: class FIFO pointers, deficits, active ring and the
// packet length RAM. Depends on drr_pkg and drr_ram.
`timescale 1ns / 1ps

module drr_core #(
  parameter int NUM_CLASSES = 4,
  parameter int FIFO_DEPTH  = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  drr_pkg::cfg_t   cfg,
  input  logic            item_valid,
  output logic            item_ready,
  input  drr_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_ready,
  output drr_pkg::result_t result
);

  localparam int CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FCW = $clog2(FIFO_DEPTH + 1);
  localparam int ACW = $clog2(NUM_CLASSES + 1);
  localparam int AW  = $clog2(NUM_CLASSES * FIFO_DEPTH);
  localparam int DW  = drr_pkg::DEF_W;

  drr_pkg::state_t state, state_next;

  logic [PW-1:0]  fhead   [NUM_CLASSES];
  logic [FCW-1:0] fcount  [NUM_CLASSES];
  logic [DW-1:0]  deficit [NUM_CLASSES];
  logic [CW-1:0]  ring    [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] active;
  logic [CW-1:0]  ahead;
  logic [ACW-1:0] acount;
  logic           qgiven;
  logic [31:0]    prod;
  drr_pkg::result_t res;

  logic           accept;
  logic           enq_ok;
  logic [CW-1:0]  ecls;
  logic [PW:0]    esum;
  logic [PW-1:0]  eslot;
  logic [CW:0]    rsum;
  logic [CW-1:0]  rslot;
  logic [CW-1:0]  ahead_inc;
  logic [CW-1:0]  cur;
  logic [PW-1:0]  cur_head_inc;
  logic [drr_pkg::QUANT_W-1:0] quantum;
  logic [DW:0]    dsum;
  logic [DW-1:0]  deff;
  logic [15:0]    plen;
  logic           fits;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [AW-1:0]  ram_raddr;
  logic           out_free;

  drr_ram #(.WIDTH(16), .DEPTH(NUM_CLASSES * FIFO_DEPTH)) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.packet_length),
    .raddr (ram_raddr),
    .rdata (plen)
  );

  // enqueue side
  assign accept = item_valid && item_ready;
  assign ecls   = item.class_index[CW-1:0];
  assign enq_ok = item.class_valid && ({1'b0, item.class_index} < 3'(NUM_CLASSES)) &&
                  (fcount[ecls] != FCW'(FIFO_DEPTH));
  assign esum   = (PW+1)'(fhead[ecls]) + (PW+1)'(fcount[ecls]);
  assign eslot  = (esum >= (PW+1)'(FIFO_DEPTH)) ? PW'(esum - (PW+1)'(FIFO_DEPTH))
                                                : esum[PW-1:0];

  // ring tail slot and head advance
  assign rsum      = (CW+1)'(ahead) + (CW+1)'(acount);
  assign rslot     = (rsum >= (CW+1)'(NUM_CLASSES)) ? CW'(rsum - (CW+1)'(NUM_CLASSES))
                                                    : rsum[CW-1:0];
  assign ahead_inc = (ahead == CW'(NUM_CLASSES - 1)) ? '0 : CW'(ahead + 1'b1);

  // visit datapath
  assign cur          = ring[ahead];
  assign cur_head_inc = (fhead[cur] == PW'(FIFO_DEPTH - 1)) ? '0 : PW'(fhead[cur] + 1'b1);
  assign quantum      = (prod[31:drr_pkg::FRAC_BITS] == '0) ? drr_pkg::QUANT_W'(1)
                                                           : prod[31:drr_pkg::FRAC_BITS];
  assign dsum         = (DW+1)'(deficit[cur]) + (DW+1)'(quantum);
  assign deff         = qgiven ? deficit[cur]
                               : (dsum[DW] ? drr_pkg::DEFICIT_MAX : dsum[DW-1:0]);
  assign fits         = DW'(plen) <= deff;
  assign out_free     = !result_valid || result_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      drr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (item.req_type == drr_pkg::REQ_ENQUEUE) ? drr_pkg::ST_DONE
                                                               : drr_pkg::ST_VISIT;
        end
      end
      drr_pkg::ST_VISIT: begin
        state_next = (acount == '0) ? drr_pkg::ST_DONE : drr_pkg::ST_EVAL;
      end
      drr_pkg::ST_EVAL: begin
        if (fcount[cur] != '0 && fits) begin
          state_next = drr_pkg::ST_DONE;
        end else begin
          state_next = drr_pkg::ST_VISIT;
        end
      end
      drr_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = drr_pkg::ST_IDLE;
        end
      end
      default: state_next = drr_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_ready = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = AW'(ecls) * AW'(FIFO_DEPTH) + AW'(eslot);
    ram_raddr  = AW'(cur) * AW'(FIFO_DEPTH) + AW'(fhead[cur]);
    unique case (state)
      drr_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        ram_we     = accept && (item.req_type == drr_pkg::REQ_ENQUEUE) && enq_ok;
      end
      drr_pkg::ST_VISIT, drr_pkg::ST_EVAL, drr_pkg::ST_DONE: begin
        item_ready = 1'b0;
      end
      default: item_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= drr_pkg::ST_IDLE;
      result_valid <= 1'b0;
      active       <= '0;
      ahead        <= '0;
      acount       <= '0;
      qgiven       <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        fhead[i]   <= '0;
        fcount[i]  <= '0;
        deficit[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == drr_pkg::ST_DONE && out_free) begin
        result       <= res;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        drr_pkg::ST_IDLE: begin
          res.accepted      <= accept && (item.req_type == drr_pkg::REQ_ENQUEUE) && enq_ok;
          res.served        <= 1'b0;
          res.served_class  <= '0;
          res.served_length <= '0;
          if (accept && item.req_type == drr_pkg::REQ_ENQUEUE && enq_ok) begin
            fcount[ecls] <= FCW'(fcount[ecls] + 1'b1);
            if (!active[ecls]) begin
              ring[rslot]   <= ecls;
              acount        <= ACW'(acount + 1'b1);
              active[ecls]  <= 1'b1;
              deficit[ecls] <= '0;
            end
          end
        end
        drr_pkg::ST_VISIT: begin
          prod <= 32'(cfg.base_quantum) * 32'(cfg.weight[2'(cur)]);
        end
        drr_pkg::ST_EVAL: begin
          if (fcount[cur] == '0) begin
            deficit[cur] <= '0;
            active[cur]  <= 1'b0;
            ahead        <= ahead_inc;
            acount       <= ACW'(acount - 1'b1);
            qgiven       <= 1'b0;
          end else if (fits) begin
            res.served        <= 1'b1;
            res.served_class  <= 2'(cur);
            res.served_length <= plen;
            fhead[cur]        <= cur_head_inc;
            fcount[cur]       <= FCW'(fcount[cur] - 1'b1);
            if (fcount[cur] == FCW'(1)) begin
              deficit[cur] <= '0;
              active[cur]  <= 1'b0;
              ahead        <= ahead_inc;
              acount       <= ACW'(acount - 1'b1);
              qgiven       <= 1'b0;
            end else begin
              deficit[cur] <= deff - DW'(plen);
              qgiven       <= 1'b1;
            end
          end else begin
            // does not fit: keep the quantum, move the class to the tail
            deficit[cur] <= deff;
            ring[rslot]  <= cur;
            ahead        <= ahead_inc;
            qgiven       <= 1'b0;
          end
        end
        drr_pkg::ST_DONE: ;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/drr_checker.sv */
// Port-level checks for the deficit round robin scheduler, bound to the top.
// Depends on drr_pkg and deficit_round_robin_scheduler_assert.svh.
`timescale 1ns / 1ps
`include "deficit_round_robin_scheduler_assert.svh"

module drr_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input drr_pkg::result_t result
);

  `DRR_ASSERT_RESET(a_reset_empty, rst, !result_valid, "result valid after reset")
  `DRR_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")
  `DRR_ASSERT_ALWAYS(a_one_kind, !(result_valid && result.accepted && result.served), "result both accepted and served")
  `DRR_ASSERT_ALWAYS(a_idle_zero, !(result_valid && !result.served && (result.served_length != 16'd0 || result.served_class != 2'd0)), "nonzero fields without service")

endmodule

bind deficit_round_robin_scheduler drr_checker u_drr_checker (.*);
